/* rtl/ade_pkg.sv */
// Shared constants for the array deque engine: defaults, command and status codes.
package ade_pkg;

  localparam int unsigned DEF_CAPACITY   = 256;
  localparam int unsigned DEF_ELEM_WIDTH = 32;

  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

/* rtl/ade_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module ade_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/array_deque_engine.sv */
// Top level of the array deque engine: command sequencer around the element RAM.
//
// Usage: drive cmd, index and value and raise start; the item is taken at a
// rising edge where start is high and busy is low. Exactly one result per item
// appears on data, status and count for one cycle, marked by done; the
// receiver cannot hold it off, so it must sample done every cycle.
// Get and set read the target slot and then reply; a rejected command replies
// without leaving idle. Insert and remove move n elements, at most CAPACITY/2.
// The shift moves one element per cycle through the single read and single
// write port of the RAM, with the read and the write of adjacent moves
// overlapped, and the last write drains before the final step. busy is low
// again in the cycle that done is high, so the next item may be taken at the
// edge that ends the result cycle.
// Reset (synchronous, active high) empties the deque: front pointer and fill
// count return to zero; element RAM contents are left as they are, since no
// command reads a slot that does not hold a live element.
module array_deque_engine
  import ade_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [8:0]         index,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] data,
  output logic [1:0]         status,
  output logic [8:0]         count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned IW = (CW > 9) ? CW : 9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WAIT,
    S_SHIFT,
    S_FINAL
  } state_t;

  state_t                state;
  logic [1:0]            cmd_r;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [CW-1:0]         idx_r;
  logic [AW-1:0]         tgt;
  logic [AW-1:0]         front;
  logic [CW-1:0]         fill;
  logic [AW-1:0]         rptr;
  logic [CW-1:0]         mcnt;
  logic                  up;
  logic                  front_side;
  logic                  pend;
  logic [AW-1:0]         pend_addr;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  logic signed [63:0]           val64;
  logic [ELEM_WIDTH-1:0]        elem_in;
  logic signed [ELEM_WIDTH-1:0] rd_s;
  logic signed [63:0]           rd64;
  logic signed [31:0]           rd_data;
  logic [IW-1:0]                idx_x;
  logic [IW-1:0]                fill_x;
  logic [CW-1:0]                ieff;
  logic [CW-1:0]                half;

  assign busy = (state != S_IDLE);

  // Element width conversion: sign-extend the input, keep the low bits; on
  // the way out sign-extend from the element width and keep 32 bits.
  assign val64   = 64'(value);
  assign elem_in = val64[ELEM_WIDTH-1:0];
  assign rd_s    = ram_rdata;
  assign rd64    = 64'(rd_s);
  assign rd_data = rd64[31:0];

  assign idx_x  = IW'(index);
  assign fill_x = IW'(fill);
  assign ieff   = (idx_x > fill_x) ? fill : CW'(idx_x);
  assign half   = fill >> 1;

  // A pending move write always wins; it never overlaps a set or final write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt;
    ram_wdata = val_r;
    if (pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = ram_rdata;
    end else if (state == S_WAIT && cmd_r == CMD_SET) begin
      ram_we = 1'b1;
    end else if (state == S_FINAL && cmd_r == CMD_INSERT) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = (state == S_SHIFT) ? rptr : tgt;

  ade_ram #(
    .WIDTH(ELEM_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      front <= '0;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      // Each issued read is written one slot over in the following cycle.
      pend      <= (state == S_SHIFT) && (mcnt != '0);
      pend_addr <= up ? (rptr - AW'(1)) : (rptr + AW'(1));

      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            val_r <= elem_in;
            idx_r <= ieff;
            unique case (cmd) inside
              CMD_GET, CMD_SET: begin
                if (idx_x >= fill_x) begin
                  done   <= 1'b1;
                  data   <= '0;
                  status <= ST_RANGE;
                  count  <= 9'(fill);
                end else begin
                  tgt   <= front + AW'(ieff);
                  state <= S_RD;
                end
              end
              CMD_INSERT: begin
                if (fill == CW'(CAPACITY)) begin
                  done   <= 1'b1;
                  data   <= '0;
                  status <= ST_FULL;
                  count  <= 9'(fill);
                end else if (ieff < half) begin
                  // Front side slides down by one; the new element lands
                  // just before the old slot at the clamped index.
                  front_side <= 1'b1;
                  up         <= 1'b1;
                  rptr       <= front;
                  mcnt       <= ieff;
                  tgt        <= front + AW'(ieff) - AW'(1);
                  state      <= S_SHIFT;
                end else begin
                  front_side <= 1'b0;
                  up         <= 1'b0;
                  rptr       <= front + AW'(fill) - AW'(1);
                  mcnt       <= fill - ieff;
                  tgt        <= front + AW'(ieff);
                  state      <= S_SHIFT;
                end
              end
              CMD_REMOVE: begin
                if (fill == '0) begin
                  done   <= 1'b1;
                  data   <= '0;
                  status <= ST_EMPTY;
                  count  <= 9'(fill);
                end else if (idx_x >= fill_x) begin
                  done   <= 1'b1;
                  data   <= '0;
                  status <= ST_RANGE;
                  count  <= 9'(fill);
                end else begin
                  tgt   <= front + AW'(ieff);
                  state <= S_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          data <= rd_data;
          if (cmd_r == CMD_REMOVE) begin
            if (idx_r < half) begin
              front_side <= 1'b1;
              up         <= 1'b0;
              rptr       <= tgt - AW'(1);
              mcnt       <= idx_r;
            end else begin
              front_side <= 1'b0;
              up         <= 1'b1;
              rptr       <= tgt + AW'(1);
              mcnt       <= fill - idx_r - CW'(1);
            end
            state <= S_SHIFT;
          end else begin
            done   <= 1'b1;
            status <= ST_OK;
            count  <= 9'(fill);
            state  <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (mcnt != '0) begin
            rptr <= up ? (rptr + AW'(1)) : (rptr - AW'(1));
            mcnt <= mcnt - CW'(1);
          end else if (!pend) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          done   <= 1'b1;
          status <= ST_OK;
          if (cmd_r == CMD_INSERT) begin
            data  <= '0;
            fill  <= fill + CW'(1);
            count <= 9'(fill + CW'(1));
            if (front_side) begin
              front <= front - AW'(1);
            end
          end else begin
            fill  <= fill - CW'(1);
            count <= 9'(fill - CW'(1));
            if (front_side) begin
              front <= front + AW'(1);
            end
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench for array_deque_engine: random and directed deque commands checked against a mirror.
`timescale 1ns / 100ps

module tb_top;
  import ade_pkg::*;

  localparam int DEPTH       = 256;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RAND_ITEMS  = 900;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [1:0]         op;
    logic [8:0]         pos;
    logic signed [31:0] elem;
    bit                 hold;
  } deque_cmd_t;

  typedef struct {
    logic [31:0] data;
    logic [1:0]  status;
    logic [8:0]  count;
  } deque_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = CMD_GET;
  logic [8:0]         index = '0;
  logic signed [31:0] value = '0;
  logic               done;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic [8:0]         count;

  array_deque_engine u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .index  (index),
    .value  (value),
    .done   (done),
    .data   (data),
    .status (status),
    .count  (count)
  );

  always #2 clk = ~clk;

  // Mirror of the deque contents and pointers.
  logic [31:0] mirror_mem [DEPTH];
  logic [7:0]  mirror_head = '0;
  logic [8:0]  mirror_len  = '0;

  deque_cmd_t   cmd_q [$];
  deque_reply_t reply_q [$];
  int           mismatch_count = 0;
  int           gap_cnt = 0;
  int           burst_left = 0;

  function automatic logic [7:0] phys(input int k);
    return mirror_head + k[7:0];
  endfunction

  task automatic deque_apply(input logic [1:0] op, input logic [8:0] pos,
                             input logic [31:0] elem, output deque_reply_t r);
    logic [8:0] p;
    r.data   = '0;
    r.status = ST_OK;
    case (op) inside
      CMD_GET, CMD_SET: begin
        if (pos >= mirror_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = mirror_mem[phys(pos)];
          if (op == CMD_SET) mirror_mem[phys(pos)] = elem;
        end
      end
      CMD_INSERT: begin
        if (mirror_len == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          p = (pos > mirror_len) ? mirror_len : pos;
          // The front side moves when the index is below half the length; shifting the front side moves the head back.
          if (p < mirror_len / 2) begin
            mirror_head = mirror_head - 8'd1;
            for (int k = 0; k < p; k++) mirror_mem[phys(k)] = mirror_mem[phys(k + 1)];
          end else begin
            for (int k = mirror_len; k > p; k--) mirror_mem[phys(k)] = mirror_mem[phys(k - 1)];
          end
          mirror_mem[phys(p)] = elem;
          mirror_len = mirror_len + 9'd1;
        end
      end
      default: begin
        if (mirror_len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= mirror_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = mirror_mem[phys(pos)];
          if (pos < mirror_len / 2) begin
            for (int k = pos; k > 0; k--) mirror_mem[phys(k)] = mirror_mem[phys(k - 1)];
            mirror_head = mirror_head + 8'd1;
          end else begin
            for (int k = pos; k + 1 < mirror_len; k++) mirror_mem[phys(k)] = mirror_mem[phys(k + 1)];
          end
          mirror_len = mirror_len - 9'd1;
        end
      end
    endcase
    r.count = mirror_len;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Driver: presents the next item once the last is taken and its gap has run out; a hold item waits for all results.
  always @(posedge clk) begin
    logic         took;
    logic         drained;
    deque_reply_t r;
    deque_cmd_t   nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        deque_apply(cmd, index, value, r);
        reply_q.push_back(r);
        gap_cnt = pick_gap();
      end else if (gap_cnt > 0) begin
        gap_cnt--;
      end
      // A result accepted at this very edge counts as already arrived; an item
      // taken at this edge is still in flight.
      drained = !took && ((reply_q.size() == 0) || (reply_q.size() == 1 && done));
      if (took || !start) begin
        if (gap_cnt == 0 && cmd_q.size() > 0 && (!cmd_q[0].hold || drained)) begin
          nxt = cmd_q.pop_front();
          cmd   <= nxt.op;
          index <= nxt.pos;
          value <= nxt.elem;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    deque_reply_t want;
    if (!rst && done) begin
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h status=%0d count=%0d",
                                  data, status, count));
      end else begin
        want = reply_q.pop_front();
        if (data !== want.data)
          report_mismatch($sformatf("data %h, expected %h", data, want.data));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
      end
    end
  end

  // Watchdog on cycles where neither an item nor a result is accepted.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("array_deque_engine test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus planning tracks only the element count, to aim indexes in and out of range.
  int plan_n = 0;

  task automatic plan(input logic [1:0] op, input logic [8:0] pos,
                      input logic [31:0] elem, input bit hold = 1'b0);
    deque_cmd_t c;
    c.op   = op;
    c.pos  = pos;
    c.elem = elem;
    c.hold = hold;
    cmd_q.push_back(c);
    if (op == CMD_INSERT && plan_n < DEPTH) plan_n++;
    if (op == CMD_REMOVE && plan_n > 0 && pos < plan_n) plan_n--;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [8:0] pick_index(input logic [1:0] op);
    int top;
    int r;
    top = (op == CMD_INSERT) ? plan_n : plan_n - 1;
    r = $urandom_range(0, 99);
    if (r < 12 || top < 0) return 9'($urandom_range((top < 0) ? 0 : top + 1, 511));
    if (r < 20) return 9'(top);
    if (r < 28) return 9'd0;
    return 9'($urandom_range(0, top));
  endfunction

  initial begin
    logic [1:0] op;
    bit         filling;
    int         extra;
    int         r;

    // Directed: empty deque, the value extremes, clamped append, both shift sides.
    plan(CMD_GET,    9'd0,   32'h1234_5678);
    plan(CMD_REMOVE, 9'd0,   32'h0);
    plan(CMD_REMOVE, 9'd511, 32'h0);
    plan(CMD_SET,    9'd0,   32'hDEAD_BEEF);
    plan(CMD_INSERT, 9'd0,   32'h8000_0000);
    plan(CMD_INSERT, 9'd300, 32'h7FFF_FFFF);
    plan(CMD_INSERT, 9'd511, 32'hFFFF_FFFF);
    plan(CMD_INSERT, 9'd0,   32'h0000_0000);
    plan(CMD_INSERT, 9'd1,   32'hA5A5_A5A5);
    plan(CMD_INSERT, 9'd3,   32'h5A5A_5A5A);
    plan(CMD_GET,    9'd0,   32'h0);
    plan(CMD_GET,    9'd5,   32'h0);
    plan(CMD_GET,    9'd6,   32'h0);
    plan(CMD_GET,    9'd256, 32'h0);
    plan(CMD_SET,    9'd2,   32'h5555_5555);
    plan(CMD_SET,    9'd2,   32'hAAAA_AAAA);
    plan(CMD_SET,    9'd6,   32'h1);
    plan(CMD_REMOVE, 9'd10,  32'h0);
    plan(CMD_REMOVE, 9'd0,   32'h0);
    plan(CMD_REMOVE, 9'd4,   32'h0);
    plan(CMD_REMOVE, 9'd1,   32'h0, 1'b1);
    plan(CMD_GET,    9'd1,   32'h0);

    // Random: sweep from empty to full and back, biased by direction.
    filling = 1'b1;
    extra = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (filling) op = (r < 60) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
                        (r < 85) ? CMD_GET : CMD_SET;
      else         op = (r < 60) ? CMD_REMOVE : (r < 70) ? CMD_INSERT :
                        (r < 85) ? CMD_GET : CMD_SET;
      plan(op, pick_index(op), pick_value(), (n % 150) == 75);
      if ((filling && plan_n == DEPTH) || (!filling && plan_n == 0)) begin
        extra++;
        if (extra > 8) begin
          filling = !filling;
          extra = 0;
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start || reply_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cmd_q.size() == 0 && reply_q.size() == 0) begin
      $display("array_deque_engine test passed");
    end else begin
      $display("array_deque_engine test failed");
    end
    $finish;
  end

endmodule
